// File: sv/lcns_pkg.sv
`timescale 1ns / 1ps

package lcns_pkg;

  // default grid size
  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 32;

  // widths of the item fields and of internal coordinates
  localparam int FIELD_W = 5;
  localparam int COORD_W = FIELD_W + 1;  // holds one past the last field value
  localparam int CNT_W   = 4;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // B3/S23 window counts (window includes the cell itself)
  localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_HI  = CNT_W'(4);

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch a query and set up the window scan
    logic wr;     // write one cell from the request
    logic clr;    // clearing pass: write one dead cell
    logic scan;   // read one window cell
    logic emit;   // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_query;
    logic in_grid;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// File: sv/life_cell_next_state.sv
`timescale 1ns / 1ps

// Game of Life cell block (B3/S23) over a ROWS x COLS grid of one-bit cells held
// in a single-port memory. A write request is done in the cycle it is taken.
// A query takes the request, makes one memory read per cell of its clipped
// 3x3 window (4, 6 or 9 cells), waits in a drain state for the last read to
// return and applies the rule in a decide state, which waits while a result
// is held stalled; a query outside the grid goes straight to the decide state.
// After reset a clearing pass clears the ROWS*COLS cells with req_stall high.
// The result register lets writes and the next query proceed while a result
// waits to be taken.
module life_cell_next_state #(
  parameter int ROWS = lcns_pkg::ROWS_DEF,
  parameter int COLS = lcns_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [lcns_pkg::FIELD_W-1:0]  row,
  input  logic [lcns_pkg::FIELD_W-1:0]  col,
  input  logic                          alive_in,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          next_alive,
  output logic [lcns_pkg::CNT_W-1:0]    live_in_window
);

  lcns_pkg::cmd_t  cmd;
  lcns_pkg::stat_t stat;

  // controller
  lcns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath with grid memory
  lcns_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .row            (row),
    .col            (col),
    .alive_in       (alive_in),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .next_alive     (next_alive),
    .live_in_window (live_in_window),
    .cmd            (cmd),
    .stat           (stat)
  );

  // end of clearing pass opens the request side
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    cmd.clr && stat.clr_last |=> !req_stall)
    else $error("request side still stalled after clearing pass");

  // a decided result is presented
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> rsp_valid)
    else $error("result not presented after emit");

  // window count stays within a 3x3 window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> live_in_window <= lcns_pkg::CNT_W'(9))
    else $error("window count out of range");

  // a live next state needs a count of 3 or 4
  a_rule: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && next_alive |-> (live_in_window == lcns_pkg::BIRTH_CNT) ||
                                (live_in_window == lcns_pkg::SURVIVE_HI))
    else $error("next state alive with wrong count");

endmodule

// File: sv/lcns_ctrl.sv
`timescale 1ns / 1ps

module lcns_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lcns_pkg::stat_t stat,
  output lcns_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (stat.is_query) begin
            cmd.load   = 1'b1;
            state_next = stat.in_grid ? S_SCAN : S_DECIDE;
          end else begin
            cmd.wr = stat.in_grid;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/lcns_dp.sv
`timescale 1ns / 1ps

module lcns_dp #(
  parameter int ROWS = lcns_pkg::ROWS_DEF,
  parameter int COLS = lcns_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_type,
  input  logic [lcns_pkg::FIELD_W-1:0]    row,
  input  logic [lcns_pkg::FIELD_W-1:0]    col,
  input  logic                            alive_in,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            next_alive,
  output logic [lcns_pkg::CNT_W-1:0]      live_in_window,
  input  lcns_pkg::cmd_t                  cmd,
  output lcns_pkg::stat_t                 stat
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = lcns_pkg::COORD_W;
  localparam logic [CW-1:0] ROW_LAST = CW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

  // grid memory, one cell per entry
  logic mem [DEPTH];
  logic mem_q;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;
  logic              mem_wd;

  logic [CW-1:0] row_w, col_w;
  logic [CW-1:0] row_q, col_q;
  logic [CW-1:0] k, l;
  logic [CW-1:0] r1, c0, c1;
  logic [CW-1:0] r0_in, r1_in, c0_in, c1_in;
  logic          rd_pending;
  logic          rd_self;
  logic [lcns_pkg::CNT_W-1:0] count;
  logic          self_alive;
  logic          decide;

  assign row_w = CW'(row);
  assign col_w = CW'(col);

  // clipped window bounds of the requested cell
  assign r0_in = (row_w == '0) ? '0 : row_w - CW'(1);
  assign c0_in = (col_w == '0) ? '0 : col_w - CW'(1);
  assign r1_in = (32'(row) + 32'd1 < ROWS) ? row_w + CW'(1) : ROW_LAST;
  assign c1_in = (32'(col) + 32'd1 < COLS) ? col_w + CW'(1) : COL_LAST;

  // memory address select: clearing pass, cell write, window scan
  always_comb begin
    priority if (cmd.clr) begin
      addr   = clr_addr;
      mem_we = 1'b1;
      mem_wd = 1'b0;
    end else if (cmd.wr) begin
      addr   = ADDR_W'(32'(row) * COLS + 32'(col));
      mem_we = 1'b1;
      mem_wd = alive_in;
    end else begin
      addr   = ADDR_W'(32'(k) * COLS + 32'(l));
      mem_we = 1'b0;
      mem_wd = 1'b0;
    end
  end

  // single-port grid memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wd;
    end
    mem_q <= mem[addr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr && (clr_addr != ADDR_W'(DEPTH - 1))) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // window scan and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q <= row_w;
      col_q <= col_w;
      k     <= r0_in;
      l     <= c0_in;
      r1    <= r1_in;
      c0    <= c0_in;
      c1    <= c1_in;
    end else if (cmd.scan) begin
      if (l == c1) begin
        l <= c0;
        k <= k + CW'(1);
      end else begin
        l <= l + CW'(1);
      end
    end
    rd_self <= cmd.scan && (k == row_q) && (l == col_q);
    if (cmd.load) begin
      count      <= '0;
      self_alive <= 1'b0;
    end else if (rd_pending) begin
      count <= count + lcns_pkg::CNT_W'(mem_q);
      if (rd_self) begin
        self_alive <= mem_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.scan;
    end
  end

  // B3/S23 rule
  assign decide = (count == lcns_pkg::BIRTH_CNT) ||
                  (self_alive && (count == lcns_pkg::SURVIVE_HI));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      next_alive     <= decide;
      live_in_window <= count;
    end
  end

  // status to controller
  assign stat.is_query  = (req_type == lcns_pkg::REQ_QUERY);
  assign stat.in_grid   = (32'(row) < ROWS) && (32'(col) < COLS);
  assign stat.scan_last = (k == r1) && (l == c1);
  assign stat.clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.out_free  = !rsp_valid || !rsp_stall;

endmodule
